[src/iml_pkg.sv]
`default_nettype none
// ============================================================================
// iml_pkg
// Shared widths, status codes and beat types of the invariant mass unit.
// ============================================================================
package iml_pkg;

    // Width of the energy, momentum and mass fields.
    localparam int VALUE_BITS = 24;
    // Width of a squared value and of the mass squared.
    localparam int SQ_BITS = 2 * VALUE_BITS;
    // Width of the partial remainder in the square root chain.
    localparam int REM_BITS = VALUE_BITS + 2;
    // One root stage per result bit.
    localparam int ROOT_STAGES = VALUE_BITS;

    // Tolerance register.
    localparam int TOL_BITS = 20;
    localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(66);

    // Result status codes.
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] STATUS_VALID   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_CLAMPED = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_INVALID = 2'd2;

    // One beat moving through the square root chain.
    typedef struct packed {
        logic [SQ_BITS-1:0]     rad;
        logic [REM_BITS-1:0]    rem;
        logic [VALUE_BITS-1:0]  root;
        logic [STATUS_BITS-1:0] status;
    } t_root_beat;

    // One finished result beat.
    typedef struct packed {
        logic [VALUE_BITS-1:0]  mass;
        logic [STATUS_BITS-1:0] status;
    } t_result;

endpackage
`default_nettype wire

[src/invariant_mass_unit.sv]
`default_nettype none
// ============================================================================
// invariant_mass_unit
// Relativistic invariant mass of one four-momentum per beat.
// ============================================================================
// The unit takes one beat per clock cycle while o_stall is low and returns
// one result beat per input beat, in order. Each beat carries an energy and
// three signed momentum components with 8 fractional bits; the unit forms
// E^2 - |p|^2 exactly with 16 fractional bits and returns its floor square
// root with 8 fractional bits. A negative mass squared whose magnitude does
// not exceed the tolerance register is reported as clamped with a zero
// mass; a more negative one is reported invalid, also with a zero mass. An
// accepted beat passes through five stages that form the magnitudes,
// squares, momentum sum, difference and status, then 24 stages of the
// square root that produce one root bit each, then the output register.
// The whole chain advances together and freezes only while the one-entry
// skid buffer behind the output register is full, so input beats keep being
// taken while a finished result waits for the downstream side. The tolerance
// register resets to 66 (about 0.001) and should only be written while the
// unit holds no beats in flight.
// ============================================================================
module invariant_mass_unit (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration.
    input  wire logic                                  i_cfg_we,
    input  wire logic        [iml_pkg::TOL_BITS-1:0]   i_cfg_wdata,
    // Input channel.
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic        [iml_pkg::VALUE_BITS-1:0] i_energy_in,
    input  wire logic signed [iml_pkg::VALUE_BITS-1:0] i_momentum_x,
    input  wire logic signed [iml_pkg::VALUE_BITS-1:0] i_momentum_y,
    input  wire logic signed [iml_pkg::VALUE_BITS-1:0] i_momentum_z,
    // Output channel.
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic             [iml_pkg::VALUE_BITS-1:0] o_mass_out,
    output logic             [iml_pkg::STATUS_BITS-1:0] o_status
);

    localparam int NS = iml_pkg::ROOT_STAGES;

    logic [iml_pkg::TOL_BITS-1:0] r_tol;

    // The whole pipeline moves whenever the skid entry is free.
    logic w_adv;
    logic w_skid_full;

    logic                w_v    [0:NS];
    iml_pkg::t_root_beat w_beat [0:NS];

    iml_pkg::t_result w_res_in;
    iml_pkg::t_result w_res_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= iml_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    assign w_adv   = !w_skid_full;
    assign o_stall = w_skid_full;

    iml_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_valid),
        .i_energy (i_energy_in),
        .i_px     (i_momentum_x),
        .i_py     (i_momentum_y),
        .i_pz     (i_momentum_z),
        .i_tol    (r_tol),
        .o_valid  (w_v[0]),
        .o_beat   (w_beat[0])
    );

    // Square root chain: each stage settles one root bit, most significant
    // bit first.
    for (genvar g = 0; g < NS; g++) begin : g_root
        iml_root_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_v[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_v[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    // Clamped and invalid beats carry a zero radicand, so their root is zero.
    assign w_res_in.mass   = w_beat[NS].root;
    assign w_res_in.status = w_beat[NS].status;

    iml_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v[NS] && w_adv),
        .i_res       (w_res_in),
        .o_skid_full (w_skid_full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (w_res_out)
    );

    assign o_mass_out = w_res_out.mass;
    assign o_status   = w_res_out.status;

endmodule
`default_nettype wire

[src/iml_front.sv]
`default_nettype none
// ============================================================================
// iml_front
// Magnitudes, squares, momentum sum, difference and classification stages.
// ============================================================================
module iml_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_adv,
    input  wire logic                               i_valid,
    input  wire logic        [iml_pkg::VALUE_BITS-1:0] i_energy,
    input  wire logic signed [iml_pkg::VALUE_BITS-1:0] i_px,
    input  wire logic signed [iml_pkg::VALUE_BITS-1:0] i_py,
    input  wire logic signed [iml_pkg::VALUE_BITS-1:0] i_pz,
    input  wire logic        [iml_pkg::TOL_BITS-1:0]   i_tol,
    output logic                                    o_valid,
    output iml_pkg::t_root_beat                     o_beat
);

    localparam int VB = iml_pkg::VALUE_BITS;
    localparam int SB = iml_pkg::SQ_BITS;

    // Stage 0: magnitudes.
    logic          r_v0;
    logic [VB-1:0] r_e0, r_mx0, r_my0, r_mz0;
    // Stage 1: squares.
    logic          r_v1;
    logic [SB-1:0] r_e2_1, r_x2_1, r_y2_1, r_z2_1;
    // Stage 2: momentum sum.
    logic          r_v2;
    logic [SB-1:0] r_e2_2, r_p2_2;
    // Stage 3: differences in both directions.
    logic          r_v3;
    logic          r_neg3;
    logic [SB-1:0] r_pos3, r_mag3;
    // Stage 4: classification.
    logic                r_v4;
    iml_pkg::t_root_beat r_beat4;

    logic [VB-1:0] n_mx, n_my, n_mz;
    logic [SB:0]   n_diff;
    logic [SB:0]   n_rdiff;
    iml_pkg::t_root_beat n_beat;

    function automatic logic [VB-1:0] magnitude(input logic [VB-1:0] raw);
        return raw[VB-1] ? (~raw + VB'(1)) : raw;
    endfunction

    always_comb begin
        n_mx    = magnitude(i_px);
        n_my    = magnitude(i_py);
        n_mz    = magnitude(i_pz);
        n_diff  = {1'b0, r_e2_2} - {1'b0, r_p2_2};
        n_rdiff = {1'b0, r_p2_2} - {1'b0, r_e2_2};
    end

    always_comb begin
        n_beat.rem  = '0;
        n_beat.root = '0;
        if (!r_neg3) begin
            n_beat.rad    = r_pos3;
            n_beat.status = iml_pkg::STATUS_VALID;
        end else begin
            n_beat.rad = '0;
            if (r_mag3 > {{(SB-iml_pkg::TOL_BITS){1'b0}}, i_tol}) begin
                n_beat.status = iml_pkg::STATUS_INVALID;
            end else begin
                n_beat.status = iml_pkg::STATUS_CLAMPED;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_e0    <= i_energy;
            r_mx0   <= n_mx;
            r_my0   <= n_my;
            r_mz0   <= n_mz;
            r_e2_1  <= SB'(r_e0) * SB'(r_e0);
            r_x2_1  <= SB'(r_mx0) * SB'(r_mx0);
            r_y2_1  <= SB'(r_my0) * SB'(r_my0);
            r_z2_1  <= SB'(r_mz0) * SB'(r_mz0);
            r_e2_2  <= r_e2_1;
            r_p2_2  <= r_x2_1 + r_y2_1 + r_z2_1;
            r_neg3  <= n_diff[SB];
            r_pos3  <= n_diff[SB-1:0];
            r_mag3  <= n_rdiff[SB-1:0];
            r_beat4 <= n_beat;
        end
    end

    assign o_valid = r_v4;
    assign o_beat  = r_beat4;

endmodule
`default_nettype wire

[src/iml_root_stage.sv]
`default_nettype none
// ============================================================================
// iml_root_stage
// One registered step of the digit-by-digit square root: one result bit.
// ============================================================================
module iml_root_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  iml_pkg::t_root_beat   i_beat,
    output logic                  o_valid,
    output iml_pkg::t_root_beat   o_beat
);

    localparam int VB = iml_pkg::VALUE_BITS;
    localparam int SB = iml_pkg::SQ_BITS;
    localparam int RB = iml_pkg::REM_BITS;

    logic                r_valid;
    iml_pkg::t_root_beat r_beat;

    logic [RB+1:0]       n_rem_sh;
    logic [RB+1:0]       n_trial;
    logic [RB+1:0]       n_sub;
    logic                n_ge;
    iml_pkg::t_root_beat n_beat;

    // The radicand shifts up two bits per stage, so its top pair is always
    // the next pair to bring down into the remainder.
    always_comb begin
        n_rem_sh = {i_beat.rem, i_beat.rad[SB-1:SB-2]};
        n_trial  = (RB+2)'({i_beat.root, 2'b01});
        n_ge     = (n_rem_sh >= n_trial);
        n_sub    = n_rem_sh - n_trial;
        n_beat.rad    = {i_beat.rad[SB-3:0], 2'b00};
        n_beat.rem    = n_ge ? n_sub[RB-1:0] : n_rem_sh[RB-1:0];
        n_beat.root   = {i_beat.root[VB-2:0], n_ge};
        n_beat.status = i_beat.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
`default_nettype wire

[src/iml_out_buf.sv]
`default_nettype none
// ============================================================================
// iml_out_buf
// Output register with a one-entry skid buffer behind it.
// ============================================================================
module iml_out_buf (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  iml_pkg::t_result i_res,
    output logic            o_skid_full,
    output logic            o_valid,
    input  wire logic       i_stall,
    output iml_pkg::t_result o_res
);

    logic             r_out_valid;
    logic             r_skid_full;
    iml_pkg::t_result r_out;
    iml_pkg::t_result r_skid;
    logic             n_take;

    assign n_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (n_take) begin
                r_skid_full <= 1'b0;
            end
        end else if (!r_out_valid || n_take) begin
            r_out_valid <= i_valid;
        end else if (i_valid) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (n_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || n_take) begin
            r_out <= i_res;
        end else begin
            r_skid <= i_res;
        end
    end

    assign o_skid_full = r_skid_full;
    assign o_valid     = r_out_valid;
    assign o_res       = r_out;

endmodule
`default_nettype wire
